// ===== rtl/acdss_pkg.sv =====
// ----------------------------------------------------------------------------
// acdss_pkg
// Shared types and constants for the sample slip drift compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package acdss_pkg;

  localparam int NET_W      = 63;
  localparam int DIFF_W     = 64;
  localparam int LOC_W      = 32;
  localparam int ERR_W      = 11;
  localparam int ACC_W      = 32;
  localparam int CNT_W      = 17;
  localparam int TRIG_W     = 16;
  localparam int LIM_W      = 10;
  localparam int FRAMES_W   = 14;
  localparam int CH_W       = 3;
  localparam int IDX_W      = 13;
  localparam int OIDX_W     = 14;
  localparam int SLIP_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH    = 4;

  localparam logic [TRIG_W-1:0] TRIGGER_RESET = 16'd10000;
  localparam logic [LIM_W-1:0]  LIMIT_RESET   = 10'd16;

  localparam logic signed [SLIP_W-1:0] SLIP_NONE = 2'sb00;
  localparam logic signed [SLIP_W-1:0] SLIP_INC  = 2'sb01;
  localparam logic signed [SLIP_W-1:0] SLIP_DEC  = 2'sb11;
  localparam logic signed [SLIP_W-1:0] SLIP_BAD  = 2'sb10;

  localparam logic [IDX_W-1:0] IDX_ONE = 13'd1;

  typedef enum logic [1:0] {
    KIND_CLOCK  = 2'd0,
    KIND_PERIOD = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER   = 2'd0,
    REG_LIMIT     = 2'd1,
    REG_DIRECTION = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [TRIG_W-1:0] trigger;
    logic [LIM_W-1:0]  limit;
    logic              direction;
  } cfg_t;

  typedef struct packed {
    kind_t                kind;
    logic                 err_ok;
    logic [ERR_W-1:0]     err;
    logic [FRAMES_W-1:0]  frames;
    logic [CH_W-1:0]      channel;
    logic [IDX_W-1:0]     idx;
  } q_entry_t;

  localparam int ENTRY_W = $bits(q_entry_t);

endpackage

`default_nettype wire

// ===== rtl/audio_clock_drift_sample_slip_top.sv =====
// ----------------------------------------------------------------------------
// audio_clock_drift_sample_slip_top
// Clock drift compensation by slipping one sample per channel and period.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    kind, times, frames, channel, index, sample
//   out_     output     out_valid / out_ready  what, channel, index, sample, slip, last
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is accepted per cycle while the four-entry queue has room.
// Results leave one per cycle through the output register unless the output
// is stalled; an index-one sample under an inserting slip gives two results.
// Reset is synchronous; the block is ready on the first cycle after it.
// A stalled output holds period and sample items in the back part; the queue absorbs the front.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_clock_drift_sample_slip_top #(
  parameter int CHANNELS    = 8,
  parameter int MAX_FRAMES  = 8192,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [1:0]                             in_kind,
  input  wire logic [acdss_pkg::NET_W-1:0]            in_net_time,
  input  wire logic [acdss_pkg::LOC_W-1:0]            in_local_time,
  input  wire logic [acdss_pkg::FRAMES_W-1:0]         in_frames,
  input  wire logic [acdss_pkg::CH_W-1:0]             in_channel,
  input  wire logic [acdss_pkg::IDX_W-1:0]            in_sample_index,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_sample,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        out_what,
  output logic [acdss_pkg::CH_W-1:0]                  out_channel_res,
  output logic [acdss_pkg::OIDX_W-1:0]                out_out_index,
  output logic signed [SAMPLE_BITS-1:0]               out_out_sample,
  output logic signed [acdss_pkg::SLIP_W-1:0]         out_slip,
  output logic                                        out_last,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [acdss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [acdss_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import acdss_pkg::*;

  localparam int QW = ENTRY_W + SAMPLE_BITS;

  cfg_t           cfg_r;
  logic           q_full;
  logic           q_push;
  logic [QW-1:0]  q_push_data;
  logic           q_pop;
  logic           q_valid;
  logic [QW-1:0]  q_head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger   <= TRIGGER_RESET;
      cfg_r.limit     <= LIMIT_RESET;
      cfg_r.direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_TRIGGER:   cfg_r.trigger   <= cfg_data[TRIG_W-1:0];
        REG_LIMIT:     cfg_r.limit     <= cfg_data[LIM_W-1:0];
        REG_DIRECTION: cfg_r.direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  acdss_front #(
    .CHANNELS    (CHANNELS),
    .MAX_FRAMES  (MAX_FRAMES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .accept       (in_valid && in_ready),
    .kind         (in_kind),
    .net_time     (in_net_time),
    .local_time   (in_local_time),
    .frames       (in_frames),
    .channel      (in_channel),
    .sample_index (in_sample_index),
    .sample       (in_sample),
    .push         (q_push),
    .push_data    (q_push_data)
  );

  acdss_fifo #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  acdss_back #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_data          (q_head),
    .q_pop           (q_pop),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_what        (out_what),
    .out_channel_res (out_channel_res),
    .out_out_index   (out_out_index),
    .out_out_sample  (out_out_sample),
    .out_slip        (out_slip),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/acdss_fifo.sv =====
// ----------------------------------------------------------------------------
// acdss_fifo
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module acdss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/acdss_front.sv =====
// ----------------------------------------------------------------------------
// acdss_front
// Accepts input items, measures clock error and classifies them for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module acdss_front #(
  parameter int CHANNELS    = 8,
  parameter int MAX_FRAMES  = 8192,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire acdss_pkg::cfg_t                         cfg,
  input  wire logic                                    accept,
  input  wire logic [1:0]                              kind,
  input  wire logic [acdss_pkg::NET_W-1:0]             net_time,
  input  wire logic [acdss_pkg::LOC_W-1:0]             local_time,
  input  wire logic [acdss_pkg::FRAMES_W-1:0]          frames,
  input  wire logic [acdss_pkg::CH_W-1:0]              channel,
  input  wire logic [acdss_pkg::IDX_W-1:0]             sample_index,
  input  wire logic signed [SAMPLE_BITS-1:0]           sample,
  output logic                                         push,
  output logic [acdss_pkg::ENTRY_W+SAMPLE_BITS-1:0]    push_data
);

  import acdss_pkg::*;

  logic [NET_W-1:0]         last_net_r;
  logic [LOC_W-1:0]         last_loc_r;
  logic [DIFF_W-1:0]        net_diff;
  logic [LOC_W:0]           loc_diff;
  logic [DIFF_W-1:0]        err;
  logic                     err_fits;
  logic signed [ERR_W:0]    err_s;
  logic signed [ERR_W:0]    lim_s;
  logic                     chan_ok;
  logic                     idx_ok;
  q_entry_t                 entry;

  always_comb begin
    net_diff = {1'b0, net_time} - {1'b0, last_net_r};
    loc_diff = {1'b0, local_time} - {1'b0, last_loc_r};
    err      = net_diff - {{(DIFF_W - LOC_W - 1){loc_diff[LOC_W]}}, loc_diff};
    err_fits = (&err[DIFF_W-1:ERR_W-1]) | ~(|err[DIFF_W-1:ERR_W-1]);
    err_s    = $signed({err[ERR_W-1], err[ERR_W-1:0]});
    lim_s    = $signed({{(ERR_W + 1 - LIM_W){1'b0}}, cfg.limit});
    chan_ok  = ({1'b0, channel} < (CH_W + 1)'(CHANNELS));
    idx_ok   = ({1'b0, sample_index} < (IDX_W + 1)'(MAX_FRAMES));

    entry.kind    = kind_t'(kind);
    entry.err_ok  = err_fits && (err_s <= lim_s) && (err_s >= -lim_s);
    entry.err     = err[ERR_W-1:0];
    entry.frames  = frames;
    entry.channel = channel;
    entry.idx     = sample_index;

    case (kind_t'(kind))
      KIND_CLOCK:  push = accept;
      KIND_PERIOD: push = accept;
      KIND_SAMPLE: push = accept && chan_ok && idx_ok;
      default:     push = 1'b0;
    endcase
  end

  assign push_data = {entry, sample};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_net_r <= '0;
      last_loc_r <= '0;
    end else if (accept && (kind_t'(kind) == KIND_CLOCK)) begin
      last_net_r <= net_time;
      last_loc_r <= local_time;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/acdss_back.sv =====
// ----------------------------------------------------------------------------
// acdss_back
// Executes queued items: accumulator, slip decision, sample insert and drop.
// ----------------------------------------------------------------------------
`default_nettype none

module acdss_back #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire acdss_pkg::cfg_t                       cfg,
  input  wire logic                                  q_valid,
  input  wire logic [acdss_pkg::ENTRY_W+SAMPLE_BITS-1:0] q_data,
  output logic                                       q_pop,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output logic                                       out_what,
  output logic [acdss_pkg::CH_W-1:0]                 out_channel_res,
  output logic [acdss_pkg::OIDX_W-1:0]               out_out_index,
  output logic signed [SAMPLE_BITS-1:0]              out_out_sample,
  output logic signed [acdss_pkg::SLIP_W-1:0]        out_slip,
  output logic                                       out_last
);

  import acdss_pkg::*;

  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HELD_DEPTH = 1 << CH_AW;

  q_entry_t                    head;
  logic signed [SAMPLE_BITS-1:0] hs;

  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic signed [SLIP_W-1:0]    slip_r, slip_nxt;
  logic                        second_r, second_nxt;
  logic [SAMPLE_BITS-1:0]      held_r [HELD_DEPTH];
  logic                        held_we;

  logic                        out_valid_r;
  logic                        out_what_r;
  logic [CH_W-1:0]             out_ch_r;
  logic [OIDX_W-1:0]           out_idx_r;
  logic [SAMPLE_BITS-1:0]      out_smp_r;
  logic signed [SLIP_W-1:0]    out_slip_r;
  logic                        out_last_r;

  logic                        res_valid;
  logic                        res_what;
  logic [CH_W-1:0]             res_ch;
  logic [OIDX_W-1:0]           res_idx;
  logic [SAMPLE_BITS-1:0]      res_smp;
  logic signed [SLIP_W-1:0]    res_slip;
  logic                        res_last;

  logic                        slot_free;
  logic                        slip_pos;
  logic signed [ACC_W:0]       acc_sum;
  logic signed [ACC_W-1:0]     acc_sat;
  logic [CNT_W:0]              cnt_sum;
  logic [CNT_W-1:0]            cnt_clip;
  logic                        trig_hit;
  logic signed [SLIP_W-1:0]    raw_slip;
  logic signed [SLIP_W-1:0]    new_slip;
  logic [SAMPLE_BITS-1:0]      held_val;
  logic [SAMPLE_BITS:0]        avg_sum;
  logic [SAMPLE_BITS-1:0]      avg;

  assign head = q_entry_t'(q_data[ENTRY_W+SAMPLE_BITS-1:SAMPLE_BITS]);
  assign hs   = $signed(q_data[SAMPLE_BITS-1:0]);

  always_comb begin
    slot_free = !out_valid_r || out_ready;
    slip_pos  = (slip_r == SLIP_INC);

    acc_sum = {acc_r[ACC_W-1], acc_r}
            + {{(ACC_W + 1 - ERR_W){head.err[ERR_W-1]}}, head.err};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end

    cnt_sum  = {1'b0, cnt_r} + {{(CNT_W + 1 - FRAMES_W){1'b0}}, head.frames};
    cnt_clip = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
    trig_hit = (cnt_clip >= {{(CNT_W - TRIG_W){1'b0}}, cfg.trigger});
    if (!trig_hit) begin
      raw_slip = SLIP_NONE;
    end else if (acc_r < 0) begin
      raw_slip = SLIP_DEC;
    end else if (acc_r > 0) begin
      raw_slip = SLIP_INC;
    end else begin
      raw_slip = SLIP_NONE;
    end
    new_slip = cfg.direction ? -raw_slip : raw_slip;

    held_val = held_r[head.channel[CH_AW-1:0]];
    avg_sum  = {held_val[SAMPLE_BITS-1], held_val} + {hs[SAMPLE_BITS-1], hs};
    avg      = avg_sum[SAMPLE_BITS:1];

    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    slip_nxt   = slip_r;
    second_nxt = second_r;
    held_we    = 1'b0;
    q_pop      = 1'b0;
    res_valid  = 1'b0;
    res_what   = 1'b0;
    res_ch     = '0;
    res_idx    = '0;
    res_smp    = '0;
    res_slip   = SLIP_NONE;
    res_last   = 1'b1;

    if (q_valid) begin
      case (head.kind)
        KIND_CLOCK: begin
          q_pop = 1'b1;
          if (head.err_ok) begin
            acc_nxt = acc_sat;
          end
        end
        KIND_PERIOD: begin
          if (slot_free) begin
            q_pop     = 1'b1;
            res_valid = 1'b1;
            res_what  = 1'b1;
            res_slip  = new_slip;
            cnt_nxt   = trig_hit ? cnt_clip - {{(CNT_W - TRIG_W){1'b0}}, cfg.trigger}
                                 : cnt_clip;
            acc_nxt   = acc_r - {{(ACC_W - SLIP_W){raw_slip[SLIP_W-1]}}, raw_slip};
            slip_nxt  = new_slip;
          end
        end
        KIND_SAMPLE: begin
          if (slot_free) begin
            res_ch   = head.channel;
            res_slip = slip_r;
            res_smp  = hs;
            if (slip_r == SLIP_NONE) begin
              q_pop     = 1'b1;
              res_valid = 1'b1;
              res_idx   = {1'b0, head.idx};
            end else if (head.idx == '0) begin
              q_pop     = 1'b1;
              held_we   = 1'b1;
              res_valid = slip_pos;
            end else if (head.idx == IDX_ONE) begin
              res_valid = 1'b1;
              if (!slip_pos) begin
                q_pop   = 1'b1;
                res_smp = avg;
              end else if (!second_r) begin
                res_idx    = OIDX_W'(1);
                res_smp    = avg;
                res_last   = 1'b0;
                second_nxt = 1'b1;
              end else begin
                q_pop      = 1'b1;
                res_idx    = OIDX_W'(2);
                second_nxt = 1'b0;
              end
            end else begin
              q_pop     = 1'b1;
              res_valid = 1'b1;
              res_idx   = slip_pos ? {1'b0, head.idx} + OIDX_W'(1)
                                   : {1'b0, head.idx} - OIDX_W'(1);
            end
          end
        end
        default: q_pop = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      slip_r      <= SLIP_NONE;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      slip_r   <= slip_nxt;
      second_r <= second_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (held_we) begin
      held_r[head.channel[CH_AW-1:0]] <= hs;
    end
    if (res_valid) begin
      out_what_r <= res_what;
      out_ch_r   <= res_ch;
      out_idx_r  <= res_idx;
      out_smp_r  <= res_smp;
      out_slip_r <= res_slip;
      out_last_r <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_what        = out_what_r;
  assign out_channel_res = out_ch_r;
  assign out_out_index   = out_idx_r;
  assign out_out_sample  = $signed(out_smp_r);
  assign out_slip        = out_slip_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_second_head: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> (q_valid && head.kind == KIND_SAMPLE && head.idx == IDX_ONE
                  && slip_r == SLIP_INC))
    else $error("second result pending without matching head item");

  a_slip_code: assert property (@(posedge clk) disable iff (!rst_n)
    slip_r != SLIP_BAD)
    else $error("slip register holds an invalid code");

  a_period_report: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head.kind == KIND_PERIOD) |=> (out_valid_r && out_what_r && out_last_r))
    else $error("period start did not produce a slip report");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && (head.kind == KIND_CLOCK || head.kind == KIND_PERIOD)) |=> $stable(acc_r))
    else $error("accumulator moved without a clock or period item");
`endif

endmodule

`default_nettype wire
